[hdl/bwcs_pkg.sv]
// Package for the bilinear window correlation sampler.
// Holds sizes, field widths and configuration register indexes; no dependencies.
`timescale 1ns / 1ps
package bwcs_pkg;
   localparam int MAX_DIM     = 64;
   localparam int MAX_RADIUS  = 3;
   localparam int DEPTH       = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int FRAC_W      = 12;
   localparam int POS_W       = 26;
   localparam int WGT_W       = 26;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_SCALE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_SCALE_REC = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_DIM      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PYR_LEVEL     = 3'd4;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;
endpackage

[hdl/bwcs_req_if.sv]
// Request channel interface: valid/ready handshake with load and query fields.
// Depends on nothing else.
`timescale 1ns / 1ps
interface bwcs_req_if;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [11:0]       map_index;
   logic signed [7:0] corr_value;
   logic [5:0]        pixel_x;
   logic [5:0]        pixel_y;
   logic signed [7:0] flow_x;
   logic signed [7:0] flow_y;
   modport source (output valid, mode, map_index, corr_value, pixel_x, pixel_y, flow_x,
                   flow_y, input ready);
   modport sink (input valid, mode, map_index, corr_value, pixel_x, pixel_y, flow_x,
                 flow_y, output ready);
endinterface

[hdl/bwcs_rsp_if.sv]
// Response channel interface: valid/ready handshake with one window sample.
// Depends on nothing else.
`timescale 1ns / 1ps
interface bwcs_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] sample_value;
   logic [5:0]        window_index;
   logic              last;
   modport source (output valid, sample_value, window_index, last, input ready);
   modport sink (input valid, sample_value, window_index, last, output ready);
endinterface

[hdl/bwcs_map_ram.sv]
// Correlation map storage: one write port, one read port with registered data.
// Depends on bwcs_pkg for depth and address width.
`timescale 1ns / 1ps
module bwcs_map_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [bwcs_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic [bwcs_pkg::ADDR_W-1:0]  rd_addr,
   output logic [7:0]                   rd_data
);
   logic [7:0] mem [bwcs_pkg::DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/bilinear_window_correlation_sampler.sv]
// Top level of the bilinear window correlation sampler.
// Depends on bwcs_pkg, bwcs_req_if, bwcs_rsp_if and bwcs_map_ram.
//
// Usage: the request channel carries loads (mode 0) and queries (mode 1).
// A load transfer writes one byte of the correlation map and yields no
// response; loads are taken one per cycle while no query runs. A query
// transfer yields one response per window cell, (2*radius+1)^2 of them in
// row-major order, with last set on the final cell.
// A query first sets up the position and then the four bilinear weights, then
// handles each window cell in turn: four map reads through the single read
// port of the map RAM, a drain of the multiply-accumulate pipeline behind it,
// one scaling multiply and the output load. The request channel is not
// ready while a query runs.
// The response sits in an output register; if the receiver stalls, the
// sequencer waits at that cell until the register is taken.
// Synchronous reset returns the configuration registers to their defaults
// and clears control state; map contents are undefined until loaded.
// Configuration writes through the csr port take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
module bilinear_window_correlation_sampler (
   input  logic                                clock,
   input  logic                                reset,
   bwcs_req_if.sink                            req_if,
   bwcs_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [bwcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bwcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   typedef enum logic [2:0] {
      S_IDLE, S_POS, S_WGT, S_CELL, S_DRAIN, S_SCALE, S_OUT
   } state_type;

   state_type   state_ff;
   logic [15:0] flow_scale_ff, out_rec_ff;
   logic [6:0]  full_dim_ff;
   logic [1:0]  radius_ff, level_ff;

   logic [5:0]                          px_ff, py_ff;
   logic signed [24:0]                  prodx_ff, prody_ff;
   logic signed [bwcs_pkg::POS_W-1:0]   posx_ff, posy_ff;
   logic [bwcs_pkg::WGT_W-1:0]          wgt_ff [4];
   logic [1:0]                          k_ff, k1_ff;
   logic                                rd_v1_ff, inb1_ff, pv_ff;
   logic signed [33:0]                  prod_ff, acc_ff;
   logic signed [50:0]                  t_ff;
   logic [2:0]                          wx_ff, wy_ff;

   logic              rsp_valid_ff, rsp_last_ff;
   logic signed [7:0] rsp_value_ff;
   logic [5:0]        rsp_widx_ff;

   // Effective geometry.
   logic [6:0] dim, side;
   logic [2:0] wside;
   assign dim   = (full_dim_ff > 7'(bwcs_pkg::MAX_DIM)) ? 7'(bwcs_pkg::MAX_DIM) : full_dim_ff;
   assign side  = dim >> level_ff;
   assign wside = {radius_ff, 1'b1};

   // Neighbour coordinate for the read issued this cycle.
   logic signed [15:0] nx, ny;
   logic               inb;
   logic [12:0]        addr_full;
   logic [bwcs_pkg::ADDR_W-1:0] rd_addr;
   always_comb begin
      nx = 16'(posx_ff >>> bwcs_pkg::FRAC_W) - 16'(radius_ff) + 16'(wx_ff) + 16'(k_ff[0]);
      ny = 16'(posy_ff >>> bwcs_pkg::FRAC_W) - 16'(radius_ff) + 16'(wy_ff) + 16'(k_ff[1]);
      inb = !nx[15] && !ny[15] && (nx[14:0] < 15'(side)) && (ny[14:0] < 15'(side));
      addr_full = 13'(ny[5:0] * side) + 13'(nx[5:0]);
      rd_addr = addr_full[bwcs_pkg::ADDR_W-1:0];
   end

   logic [7:0] rd_data;
   logic       load_fire, query_fire;
   assign load_fire  = req_if.valid && req_if.ready && (req_if.mode == bwcs_pkg::MODE_LOAD);
   assign query_fire = req_if.valid && req_if.ready && (req_if.mode == bwcs_pkg::MODE_QUERY);

   bwcs_map_ram u_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_if.map_index),
      .wr_data (req_if.corr_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Weight factors for the weight under construction.
   logic [12:0] ax_ext, ay_ext, fa, fb;
   always_comb begin
      ax_ext = {1'b0, posx_ff[bwcs_pkg::FRAC_W-1:0]};
      ay_ext = {1'b0, posy_ff[bwcs_pkg::FRAC_W-1:0]};
      fa = k_ff[0] ? ax_ext : 13'd4096 - ax_ext;
      fb = k_ff[1] ? ay_ext : 13'd4096 - ay_ext;
   end

   // Round toward zero of t / 2^32, then saturate.
   logic signed [50:0] t_adj;
   logic signed [18:0] q;
   logic signed [7:0]  q_sat;
   always_comb begin
      t_adj = t_ff[50] ? t_ff + 51'sh0_FFFF_FFFF : t_ff;
      q = 19'(t_adj >>> 32);
      if (q > 19'sd127) begin
         q_sat = 8'sd127;
      end else if (q < -19'sd128) begin
         q_sat = -8'sd128;
      end else begin
         q_sat = q[7:0];
      end
   end

   logic cell_last;
   assign cell_last = (wx_ff == wside - 3'd1) && (wy_ff == wside - 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_scale_ff <= 16'd4096;
         out_rec_ff    <= 16'd256;
         full_dim_ff   <= 7'd64;
         radius_ff     <= 2'd3;
         level_ff      <= 2'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            bwcs_pkg::CSR_FLOW_SCALE:    flow_scale_ff <= csr_wdata;
            bwcs_pkg::CSR_OUT_SCALE_REC: out_rec_ff    <= csr_wdata;
            bwcs_pkg::CSR_FULL_DIM:      full_dim_ff   <= csr_wdata[6:0];
            bwcs_pkg::CSR_RADIUS:        radius_ff     <= csr_wdata[1:0];
            bwcs_pkg::CSR_PYR_LEVEL:     level_ff      <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_v1_ff     <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= 2'd0;
         wx_ff        <= 3'd0;
         wy_ff        <= 3'd0;
      end else begin
         // In S_OUT the output register is handled by the state itself.
         if (rsp_valid_ff && rsp_if.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         // Read and multiply-accumulate pipeline behind the map RAM.
         rd_v1_ff <= (state_ff == S_CELL);
         k1_ff    <= k_ff;
         inb1_ff  <= inb;
         pv_ff    <= rd_v1_ff;
         if (rd_v1_ff) begin
            prod_ff <= 34'($signed({1'b0, wgt_ff[k1_ff]}) *
                           (inb1_ff ? $signed(rd_data) : 8'sd0));
         end
         if (pv_ff) begin
            acc_ff <= acc_ff + prod_ff;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (query_fire) begin
                  px_ff    <= req_if.pixel_x;
                  py_ff    <= req_if.pixel_y;
                  prodx_ff <= 25'(req_if.flow_x * $signed({1'b0, flow_scale_ff}));
                  prody_ff <= 25'(req_if.flow_y * $signed({1'b0, flow_scale_ff}));
                  state_ff <= S_POS;
               end
            end
            S_POS: begin
               posx_ff  <= ($signed({8'd0, px_ff, 12'd0}) + 26'(prodx_ff)) >>> level_ff;
               posy_ff  <= ($signed({8'd0, py_ff, 12'd0}) + 26'(prody_ff)) >>> level_ff;
               k_ff     <= 2'd0;
               state_ff <= S_WGT;
            end
            S_WGT: begin
               wgt_ff[k_ff] <= 26'(fa * fb);
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  wx_ff    <= 3'd0;
                  wy_ff    <= 3'd0;
                  acc_ff   <= '0;
                  state_ff <= S_CELL;
               end
            end
            S_CELL: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!rd_v1_ff && !pv_ff) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               t_ff     <= 51'(acc_ff * $signed({1'b0, out_rec_ff})) + 51'sh8000_0000;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= q_sat;
                  rsp_widx_ff  <= 6'(wy_ff * wside) + 6'(wx_ff);
                  rsp_last_ff  <= cell_last;
                  acc_ff       <= '0;
                  if (cell_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     if (wx_ff == wside - 3'd1) begin
                        wx_ff <= 3'd0;
                        wy_ff <= wy_ff + 3'd1;
                     end else begin
                        wx_ff <= wx_ff + 3'd1;
                     end
                     state_ff <= S_CELL;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample_value = rsp_value_ff;
   assign rsp_if.window_index = rsp_widx_ff;
   assign rsp_if.last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_pipe_flow: assert property (@(posedge clock) disable iff (reset)
      rd_v1_ff |=> pv_ff)
      else $error("product stage did not follow a map read");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!rd_v1_ff && !pv_ff))
      else $error("map read pipeline busy while idle");
   a_scale_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCALE) |-> (!rd_v1_ff && !pv_ff))
      else $error("scaling started before accumulation finished");
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CELL) |-> (wx_ff < wside) && (wy_ff < wside))
      else $error("window counter beyond window side");
`endif
endmodule
